// ===== sv/akrp_pkg.sv =====
// package for the aged keyed resource pool
// shared types, constants and codes; no dependencies
package akrp_pkg;

	localparam int ENTRIES_DEF  = 16;
	localparam int KEY_BITS_DEF = 48;
	localparam int KEY_W        = 48;
	localparam int BYTES_W      = 40;
	localparam int TOTAL_W      = 48;
	localparam int CNT_W        = 32;

	localparam logic [1:0] ACT_BEGIN = 2'd0;
	localparam logic [1:0] ACT_ACQ   = 2'd1;
	localparam logic [1:0] ACT_END   = 2'd2;
	localparam logic [1:0] ACT_CLEAR = 2'd3;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_HIT      = 3'd1;
	localparam logic [2:0] ST_CREATED  = 3'd2;
	localparam logic [2:0] ST_REJECTED = 3'd3;
	localparam logic [2:0] ST_FAILED   = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	localparam logic [1:0] REG_UNUSED_LIMIT = 2'd0;

	typedef struct packed {
		logic [1:0]         action;
		logic [KEY_W-1:0]   key;
		logic [BYTES_W-1:0] bytes;
		logic               req_ok;
		logic               make_ok;
	} cmd_t;

	typedef struct packed {
		logic [2:0]         status;
		logic [31:0]        entry_id;
		logic [4:0]         entry_count;
		logic [CNT_W-1:0]   hit_count;
		logic [CNT_W-1:0]   miss_count;
		logic [CNT_W-1:0]   created_count;
		logic [CNT_W-1:0]   trimmed_count;
		logic [TOTAL_W-1:0] total_bytes;
	} res_t;

endpackage

// ===== sv/akrp_if.sv =====
// valid/ready channel interfaces for the pool
// no dependencies
interface akrp_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [47:0]        request_key;
	logic [39:0]        request_bytes;
	logic               request_ok;
	logic               create_ok;
	modport source (output valid, action, request_key, request_bytes, request_ok,
		create_ok, input ready);
	modport sink (input valid, action, request_key, request_bytes, request_ok,
		create_ok, output ready);
endinterface

interface akrp_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [31:0] entry_id;
	logic [4:0]  entry_count;
	logic [31:0] hit_count;
	logic [31:0] miss_count;
	logic [31:0] created_count;
	logic [31:0] trimmed_count;
	logic [47:0] total_bytes;
	modport source (output valid, status, entry_id, entry_count, hit_count, miss_count,
		created_count, trimmed_count, total_bytes, input ready);
	modport sink (input valid, status, entry_id, entry_count, hit_count, miss_count,
		created_count, trimmed_count, total_bytes, output ready);
endinterface

// ===== sv/aged_keyed_resource_pool_top.sv =====
// top level of the aged keyed resource pool: APB register, front queue, back scanner
// depends on akrp_pkg, akrp_if, akrp_front, akrp_back
//
// channel  | dir | payload
// cmd      | in  | action, request_key, request_bytes, request_ok, create_ok
// res      | out | status, entry_id, entry_count, counters, total_bytes
// apb      | in  | unused_limit at address 0
//
// begin and acquire walk the live entries with the one-slot-per-cycle scan
// end graph and clear skip the scan; a two-deep queue lets commands wait behind a scan
// reset empties the table, zeroes counters and sets unused_limit to 3
// a stalled result holds the back end; the front still takes up to two transactions
module aged_keyed_resource_pool_top #(
	parameter int ENTRIES  = akrp_pkg::ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	akrp_cmd_if.sink    cmd,
	akrp_res_if.source  res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import akrp_pkg::*;

	logic [7:0] limit_q;
	cmd_t       in_cmd, q_cmd;
	res_t       r;
	logic       q_valid, q_pop;

	assign pready = 1'b1;
	assign prdata = (paddr == {REG_UNUSED_LIMIT}) ? {24'd0, limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) limit_q <= 8'd3;
		else if (psel && penable && pwrite && paddr == REG_UNUSED_LIMIT)
			limit_q <= pwdata[7:0];
	end

	assign in_cmd.action  = cmd.action;
	assign in_cmd.key     = cmd.request_key;
	assign in_cmd.bytes   = cmd.request_bytes;
	assign in_cmd.req_ok  = cmd.request_ok;
	assign in_cmd.make_ok = cmd.create_ok;

	akrp_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(cmd.valid), .in_ready(cmd.ready),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd)
	);

	akrp_back #(.ENTRIES(ENTRIES)) u_back (
		.clk(clk), .arst_n(arst_n), .unused_limit(limit_q), .q_valid(q_valid),
		.q_pop(q_pop), .q_cmd(q_cmd), .res_valid(res.valid), .res_ready(res.ready),
		.res(r)
	);

	assign res.status        = r.status;
	assign res.entry_id      = r.entry_id;
	assign res.entry_count   = r.entry_count;
	assign res.hit_count     = r.hit_count;
	assign res.miss_count    = r.miss_count;
	assign res.created_count = r.created_count;
	assign res.trimmed_count = r.trimmed_count;
	assign res.total_bytes   = r.total_bytes;
endmodule

// ===== sv/akrp_front.sv =====
// front end: accepts commands and holds them in a short queue
// depends on akrp_pkg
module akrp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  akrp_pkg::cmd_t      in_cmd,
	output logic                q_valid,
	input  logic                q_pop,
	output akrp_pkg::cmd_t      q_cmd
);
	import akrp_pkg::*;

	cmd_t       slot_q [2];
	logic [1:0] cnt_q;
	logic       rd_q, wr_q;
	logic       push;

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = slot_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= 1'b0;
			wr_q  <= 1'b0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= in_cmd;
	end

`ifndef SYNTHESIS
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !push) else $error("queue overflow");
	a_no_under: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> cnt_q != 2'd0) else $error("queue underflow");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= 2'd2) else $error("bad queue count");
`endif
endmodule

// ===== sv/akrp_back.sv =====
// back end: scans the entry table one slot per cycle and forms the result
// depends on akrp_pkg
module akrp_back #(
	parameter int ENTRIES  = akrp_pkg::ENTRIES_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     unused_limit,
	input  logic           q_valid,
	output logic           q_pop,
	input  akrp_pkg::cmd_t q_cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output akrp_pkg::res_t res
);
	import akrp_pkg::*;

	localparam int KEY_BITS = KEY_BITS_DEF;
	localparam int IW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [KEY_BITS-1:0] key_q   [ENTRIES];
	logic                busy_q  [ENTRIES];
	logic [31:0]         last_q  [ENTRIES];
	logic [31:0]         ident_q [ENTRIES];
	logic [BYTES_W-1:0]  size_q  [ENTRIES];
	logic [CW-1:0]       live_q;

	logic [1:0]          state_q;
	cmd_t                cmd_q;
	logic [CW-1:0]       src_q, dst_q;
	logic [31:0]         frame_q, next_id_q;
	logic [CNT_W-1:0]    hits_q, misses_q, created_q, trimmed_q;
	logic [TOTAL_W-1:0]  total_q, sum_q;
	logic                res_v_q;
	res_t                res_q;
	logic [2:0]          st_q;
	logic [31:0]         eid_q;

	logic [IW-1:0]       si, di;
	logic                in_range, hit, old;
	logic [31:0]         age;

	assign si       = src_q[IW-1:0];
	assign di       = dst_q[IW-1:0];
	assign in_range = (src_q < live_q);
	assign age      = frame_q - last_q[si];
	assign old      = (age > {24'd0, unused_limit});
	assign hit      = in_range && !busy_q[si] && (last_q[si] != frame_q)
		&& (key_q[si] == cmd_q.key[KEY_BITS-1:0]);

	assign q_pop     = (state_q == S_IDLE) && q_valid;
	assign res_valid = res_v_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			live_q    <= '0;
			src_q     <= '0;
			dst_q     <= '0;
			frame_q   <= '0;
			next_id_q <= '0;
			hits_q    <= '0;
			misses_q  <= '0;
			created_q <= '0;
			trimmed_q <= '0;
			total_q   <= '0;
			sum_q     <= '0;
			res_v_q   <= 1'b0;
		end else begin
			if (state_q == S_OUT && (!res_v_q || res_ready)) res_v_q <= 1'b1;
			else if (res_ready) res_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						src_q   <= '0;
						dst_q   <= '0;
						sum_q   <= '0;
						state_q <= S_SCAN;
						if (q_cmd.action == ACT_BEGIN) frame_q <= frame_q + 32'd1;
					end
				end
				S_SCAN: begin
					case (cmd_q.action)
						ACT_BEGIN: begin
							if (in_range) begin
								if (old) trimmed_q <= trimmed_q + 32'd1;
								else begin
									dst_q <= dst_q + CW'(1);
									sum_q <= sum_q + {{(TOTAL_W-BYTES_W){1'b0}}, size_q[si]};
								end
								src_q <= src_q + CW'(1);
							end else begin
								live_q  <= dst_q;
								total_q <= sum_q;
								state_q <= S_OUT;
							end
						end
						ACT_ACQ: begin
							if (hit) begin
								hits_q  <= hits_q + 32'd1;
								state_q <= S_OUT;
							end else if (in_range) src_q <= src_q + CW'(1);
							else begin
								state_q <= S_OUT;
								if (cmd_q.req_ok) begin
									misses_q <= misses_q + 32'd1;
									if (live_q != CW'(ENTRIES) && cmd_q.make_ok) begin
										live_q    <= live_q + CW'(1);
										next_id_q <= next_id_q + 32'd1;
										created_q <= created_q + 32'd1;
										total_q   <= total_q
											+ {{(TOTAL_W-BYTES_W){1'b0}}, cmd_q.bytes};
									end
								end
							end
						end
						ACT_CLEAR: begin
							live_q  <= '0;
							total_q <= '0;
							state_q <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_OUT: begin
					if (!res_v_q || res_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// entry payload and the result word
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && q_valid) begin
			cmd_q <= q_cmd;
			st_q  <= (q_cmd.action == ACT_ACQ) ? ST_REJECTED : ST_DONE;
			eid_q <= '0;
		end
		if (state_q == S_SCAN) begin
			case (cmd_q.action)
				ACT_BEGIN: begin
					// compaction: survivors slide down over evicted slots
					if (in_range && !old) begin
						key_q[di]   <= key_q[si];
						busy_q[di]  <= busy_q[si];
						last_q[di]  <= last_q[si];
						ident_q[di] <= ident_q[si];
						size_q[di]  <= size_q[si];
					end
				end
				ACT_ACQ: begin
					if (hit) begin
						busy_q[si] <= 1'b1;
						last_q[si] <= frame_q;
						st_q       <= ST_HIT;
						eid_q      <= ident_q[si];
					end else if (!in_range && cmd_q.req_ok) begin
						if (live_q == CW'(ENTRIES)) st_q <= ST_FULL;
						else if (!cmd_q.make_ok) st_q <= ST_FAILED;
						else begin
							key_q[si]   <= cmd_q.key[KEY_BITS-1:0];
							busy_q[si]  <= 1'b1;
							last_q[si]  <= frame_q;
							ident_q[si] <= next_id_q;
							size_q[si]  <= cmd_q.bytes;
							st_q        <= ST_CREATED;
							eid_q       <= next_id_q;
						end
					end
				end
				ACT_END: begin
					for (int i = 0; i < ENTRIES; i++) busy_q[i] <= 1'b0;
				end
				default: ;
			endcase
		end
		if (state_q == S_OUT && (!res_v_q || res_ready)) begin
			res_q.status        <= st_q;
			res_q.entry_id      <= eid_q;
			res_q.entry_count   <= 5'(live_q);
			res_q.hit_count     <= hits_q;
			res_q.miss_count    <= misses_q;
			res_q.created_count <= created_q;
			res_q.trimmed_count <= trimmed_q;
			res_q.total_bytes   <= total_q;
		end
	end

`ifndef SYNTHESIS
	a_live: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(ENTRIES)) else $error("live count overflow");
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> state_q == S_SCAN) else $error("pop without scan");
	a_dst: assert property (@(posedge clk) disable iff (!arst_n)
		dst_q <= src_q) else $error("compaction ahead of scan");
`endif
endmodule
